[sv/rrfp_pkg.sv]
// ----------------------------------------------------------------------------
// rrfp_pkg: shared types and codes for the row record field parser
// result kinds, column types, register indices, field phase encoding and the result record
// ----------------------------------------------------------------------------
package rrfp_pkg;

  localparam logic [2:0] KIND_INT       = 3'd0;
  localparam logic [2:0] KIND_LONG      = 3'd1;
  localparam logic [2:0] KIND_STR_LEN   = 3'd2;
  localparam logic [2:0] KIND_STR_BYTE  = 3'd3;
  localparam logic [2:0] KIND_BLOB_LEN  = 3'd4;
  localparam logic [2:0] KIND_BLOB_BYTE = 3'd5;
  localparam logic [2:0] KIND_FRAME_ERR = 3'd6;

  localparam logic [1:0] TYPE_INT32  = 2'd0;
  localparam logic [1:0] TYPE_INT64  = 2'd1;
  localparam logic [1:0] TYPE_STRING = 2'd2;

  localparam logic [0:0] REG_COLUMN_COUNT = 1'b0;
  localparam logic [0:0] REG_COLUMN_TYPES = 1'b1;

  typedef enum logic [3:0] {
    PH_START   = 4'b0001,
    PH_NUMBER  = 4'b0010,
    PH_LENGTH  = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [3:0]         column_index;
    logic [2:0]         item_kind;
    logic signed [63:0] field_value;
    logic               column_done;
    logic               row_done;
  } result_t;

endpackage

[sv/row_record_field_parser.sv]
// ----------------------------------------------------------------------------
// row_record_field_parser: schema driven parser for stored table rows
// results are registered in a two-entry output stage (result register and skid)
// and bytes are taken one per cycle while the skid entry is empty
// synchronous reset clears parse state, output valids, column_count=1, types=0
// ----------------------------------------------------------------------------
module row_record_field_parser #(
  parameter int MAX_COLUMNS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               data_valid,
  output logic               data_stall,
  input  logic [7:0]         data_byte,
  input  logic               end_of_record,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [3:0]         column_index,
  output logic [2:0]         item_kind,
  output logic signed [63:0] field_value,
  output logic               column_done,
  output logic               row_done
);

  localparam logic [4:0] MAX_COLS = 5'(MAX_COLUMNS);

  // configuration
  logic [4:0]  column_count;
  logic [31:0] column_types;

  // parse state
  logic [4:0]       current_column, current_column_next;
  rrfp_pkg::phase_t field_phase, field_phase_next;
  logic [15:0]      bytes_remaining, bytes_remaining_next;
  logic [63:0]      value_accumulator, value_accumulator_next;
  logic             record_mismatch, record_mismatch_next;

  // output stage
  rrfp_pkg::result_t out_reg, skid_reg, res;
  logic              skid_valid;

  logic [4:0]  ncols;
  logic [1:0]  col_type;
  logic        overrun;
  logic        have;
  logic        cdone;
  logic        good;
  logic [63:0] acc_shift;
  logic [15:0] len;
  logic [15:0] rem_dec;
  logic        accept;
  logic        out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= 5'd1;
      column_types <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rrfp_pkg::REG_COLUMN_COUNT: column_count <= cfg_data[4:0];
        rrfp_pkg::REG_COLUMN_TYPES: column_types <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (column_count == 5'd0) begin
      ncols = 5'd1;
    end else if (column_count > MAX_COLS) begin
      ncols = MAX_COLS;
    end else begin
      ncols = column_count;
    end
  end

  assign col_type  = column_types[{current_column[3:0], 1'b0} +: 2];
  assign overrun   = record_mismatch || (current_column >= ncols);
  assign acc_shift = {value_accumulator[55:0], data_byte};
  assign len       = {value_accumulator[7:0], data_byte};
  assign rem_dec   = bytes_remaining - 16'd1;

  always_comb begin
    current_column_next    = current_column;
    field_phase_next       = field_phase;
    bytes_remaining_next   = bytes_remaining;
    value_accumulator_next = value_accumulator;
    record_mismatch_next   = record_mismatch;
    have                   = 1'b0;
    cdone                  = 1'b0;
    good                   = 1'b0;
    res.column_index       = current_column[3:0];
    res.item_kind          = rrfp_pkg::KIND_INT;
    res.field_value        = '0;
    res.column_done        = 1'b0;
    res.row_done           = end_of_record;

    if (overrun) begin
      record_mismatch_next = 1'b1;
    end else begin
      unique case (field_phase)
        rrfp_pkg::PH_START: begin
          value_accumulator_next = {56'd0, data_byte};
          if (col_type == rrfp_pkg::TYPE_INT32) begin
            bytes_remaining_next = 16'd3;
            field_phase_next     = rrfp_pkg::PH_NUMBER;
          end else if (col_type == rrfp_pkg::TYPE_INT64) begin
            bytes_remaining_next = 16'd7;
            field_phase_next     = rrfp_pkg::PH_NUMBER;
          end else begin
            field_phase_next = rrfp_pkg::PH_LENGTH;
          end
        end
        rrfp_pkg::PH_NUMBER: begin
          value_accumulator_next = acc_shift;
          bytes_remaining_next   = rem_dec;
          if (rem_dec == 16'd0) begin
            have = 1'b1;
            cdone = 1'b1;
            if (col_type == rrfp_pkg::TYPE_INT64) begin
              res.item_kind   = rrfp_pkg::KIND_LONG;
              res.field_value = acc_shift;
            end else begin
              res.item_kind   = rrfp_pkg::KIND_INT;
              res.field_value = {{32{acc_shift[31]}}, acc_shift[31:0]};
            end
          end
        end
        rrfp_pkg::PH_LENGTH: begin
          have = 1'b1;
          res.item_kind = (col_type == rrfp_pkg::TYPE_STRING) ?
                          rrfp_pkg::KIND_STR_LEN : rrfp_pkg::KIND_BLOB_LEN;
          res.field_value        = {48'd0, len};
          value_accumulator_next = {48'd0, len};
          if (len == 16'd0) begin
            cdone = 1'b1;
          end else begin
            bytes_remaining_next = len;
            field_phase_next     = rrfp_pkg::PH_PAYLOAD;
          end
        end
        rrfp_pkg::PH_PAYLOAD: begin
          have = 1'b1;
          res.item_kind = (col_type == rrfp_pkg::TYPE_STRING) ?
                          rrfp_pkg::KIND_STR_BYTE : rrfp_pkg::KIND_BLOB_BYTE;
          res.field_value      = {56'd0, data_byte};
          bytes_remaining_next = rem_dec;
          if (rem_dec == 16'd0) begin
            cdone = 1'b1;
          end
        end
        default: ;
      endcase
      if (cdone) begin
        current_column_next    = current_column + 5'd1;
        field_phase_next       = rrfp_pkg::PH_START;
        bytes_remaining_next   = '0;
        value_accumulator_next = '0;
      end
    end
    res.column_done = cdone;

    if (end_of_record) begin
      good = have && cdone && !overrun && (current_column_next == ncols);
      if (!good) begin
        res.column_index = current_column_next[4] ? 4'd15 : current_column_next[3:0];
        res.item_kind    = rrfp_pkg::KIND_FRAME_ERR;
        res.field_value  = '0;
        res.column_done  = 1'b0;
      end
      have                   = 1'b1;
      current_column_next    = '0;
      field_phase_next       = rrfp_pkg::PH_START;
      bytes_remaining_next   = '0;
      value_accumulator_next = '0;
      record_mismatch_next   = 1'b0;
    end
  end

  assign data_stall = skid_valid;
  assign accept     = data_valid && !data_stall;
  assign out_take   = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_column    <= '0;
      field_phase       <= rrfp_pkg::PH_START;
      bytes_remaining   <= '0;
      value_accumulator <= '0;
      record_mismatch   <= 1'b0;
    end else if (accept) begin
      current_column    <= current_column_next;
      field_phase       <= field_phase_next;
      bytes_remaining   <= bytes_remaining_next;
      value_accumulator <= value_accumulator_next;
      record_mismatch   <= record_mismatch_next;
    end
  end

  // result register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (!result_valid || out_take) begin
      result_valid <= accept && have;
    end else if (accept && have) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_reg <= skid_reg;
      end
    end else if (!result_valid || out_take) begin
      out_reg <= res;
    end else begin
      skid_reg <= res;
    end
  end

  assign column_index = out_reg.column_index;
  assign item_kind    = out_reg.item_kind;
  assign field_value  = out_reg.field_value;
  assign column_done  = out_reg.column_done;
  assign row_done     = out_reg.row_done;

  // an end-of-record transfer always yields a result
  a_eor_result: assert property (@(posedge clk) disable iff (rst)
    data_valid && !data_stall && end_of_record |=> result_valid)
    else $error("no result after end-of-record transfer");

  // parse state restarts after the end-of-record transfer
  a_eor_restart: assert property (@(posedge clk) disable iff (rst)
    data_valid && !data_stall && end_of_record |=>
      current_column == 5'd0 && field_phase == rrfp_pkg::PH_START && !record_mismatch)
    else $error("parse state not restarted after end of record");

  // skid entry only holds data behind a waiting result
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry occupied with empty result register");

  // a framing error never completes a column
  a_frame_err: assert property (@(posedge clk) disable iff (rst)
    result_valid && item_kind == rrfp_pkg::KIND_FRAME_ERR |-> row_done && !column_done)
    else $error("malformed framing error result");

endmodule

[test/tb_row_record_field_parser.sv]
// ----------------------------------------------------------------------------
// tb_row_record_field_parser: self-checking bench for the row record parser
// a short directed table, then schema-shaped random rows with broken and
// noisy records mixed in; results are checked against the table or a predictor
// ----------------------------------------------------------------------------
module tb_row_record_field_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_COLUMNS = 16;
  localparam int          N_RANDOM    = 1530;
  localparam int          HOLD_CYCLES = 300;
  localparam int          SETTLE      = 4;
  localparam int          LIMIT       = 1000000;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [0:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               data_valid;
  logic               data_stall;
  logic [7:0]         data_byte;
  logic               end_of_record;
  logic               result_valid;
  logic               result_stall;
  logic [3:0]         column_index;
  logic [2:0]         item_kind;
  logic signed [63:0] field_value;
  logic               column_done;
  logic               row_done;

  row_record_field_parser #(.MAX_COLUMNS(MAX_COLUMNS)) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .data_valid(data_valid),
    .data_stall(data_stall),
    .data_byte(data_byte),
    .end_of_record(end_of_record),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .column_index(column_index),
    .item_kind(item_kind),
    .field_value(field_value),
    .column_done(column_done),
    .row_done(row_done)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // directed stimulus table
  typedef enum logic {OP_BYTE, OP_CFG} row_op_t;
  typedef struct {
    row_op_t     op;
    logic [0:0]  idx;
    logic [31:0] data;
    logic        eor;
    logic        typed;
    logic [3:0]  col;
    logic [2:0]  kind;
    logic [63:0] val;
    logic        cd;
  } dir_row_t;

  dir_row_t script [0:25] = '{
    // reset schema: one int column
    '{OP_BYTE, 1'b0, 32'h80, 1'b0, 1'b0, 4'd0, rrfp_pkg::KIND_INT, 64'd0, 1'b0},
    '{OP_BYTE, 1'b0, 32'h00, 1'b0, 1'b0, 4'd0, rrfp_pkg::KIND_INT, 64'd0, 1'b0},
    '{OP_BYTE, 1'b0, 32'h00, 1'b0, 1'b0, 4'd0, rrfp_pkg::KIND_INT, 64'd0, 1'b0},
    '{OP_BYTE, 1'b0, 32'h00, 1'b0, 1'b1, 4'd0, rrfp_pkg::KIND_INT,
      64'hFFFF_FFFF_8000_0000, 1'b1},
    // extra byte past the last column ends the record
    '{OP_BYTE, 1'b0, 32'h00, 1'b1, 1'b1, 4'd1, rrfp_pkg::KIND_FRAME_ERR, 64'd0, 1'b0},
    // long, string, blob, int
    '{OP_CFG, rrfp_pkg::REG_COLUMN_COUNT, 32'd4, 1'b0, 1'b0, 4'd0,
      rrfp_pkg::KIND_INT, 64'd0, 1'b0},
    '{OP_CFG, rrfp_pkg::REG_COLUMN_TYPES, 32'h39, 1'b0, 1'b0, 4'd0,
      rrfp_pkg::KIND_INT, 64'd0, 1'b0},
    '{OP_BYTE, 1'b0, 32'h7F, 1'b0, 1'b0, 4'd0, rrfp_pkg::KIND_INT, 64'd0, 1'b0},
    '{OP_BYTE, 1'b0, 32'hFF, 1'b0, 1'b0, 4'd0, rrfp_pkg::KIND_INT, 64'd0, 1'b0},
    '{OP_BYTE, 1'b0, 32'hFF, 1'b0, 1'b0, 4'd0, rrfp_pkg::KIND_INT, 64'd0, 1'b0},
    '{OP_BYTE, 1'b0, 32'hFF, 1'b0, 1'b0, 4'd0, rrfp_pkg::KIND_INT, 64'd0, 1'b0},
    '{OP_BYTE, 1'b0, 32'hFF, 1'b0, 1'b0, 4'd0, rrfp_pkg::KIND_INT, 64'd0, 1'b0},
    '{OP_BYTE, 1'b0, 32'hFF, 1'b0, 1'b0, 4'd0, rrfp_pkg::KIND_INT, 64'd0, 1'b0},
    '{OP_BYTE, 1'b0, 32'hFF, 1'b0, 1'b0, 4'd0, rrfp_pkg::KIND_INT, 64'd0, 1'b0},
    '{OP_BYTE, 1'b0, 32'hFF, 1'b0, 1'b1, 4'd0, rrfp_pkg::KIND_LONG,
      64'h7FFF_FFFF_FFFF_FFFF, 1'b1},
    '{OP_BYTE, 1'b0, 32'h00, 1'b0, 1'b0, 4'd0, rrfp_pkg::KIND_INT, 64'd0, 1'b0},
    '{OP_BYTE, 1'b0, 32'h02, 1'b0, 1'b1, 4'd1, rrfp_pkg::KIND_STR_LEN, 64'd2, 1'b0},
    '{OP_BYTE, 1'b0, 32'h41, 1'b0, 1'b0, 4'd0, rrfp_pkg::KIND_INT, 64'd0, 1'b0},
    '{OP_BYTE, 1'b0, 32'h5A, 1'b0, 1'b1, 4'd1, rrfp_pkg::KIND_STR_BYTE, 64'h5A, 1'b1},
    '{OP_BYTE, 1'b0, 32'h00, 1'b0, 1'b0, 4'd0, rrfp_pkg::KIND_INT, 64'd0, 1'b0},
    '{OP_BYTE, 1'b0, 32'h00, 1'b0, 1'b1, 4'd2, rrfp_pkg::KIND_BLOB_LEN, 64'd0, 1'b1},
    '{OP_BYTE, 1'b0, 32'h12, 1'b0, 1'b0, 4'd0, rrfp_pkg::KIND_INT, 64'd0, 1'b0},
    '{OP_BYTE, 1'b0, 32'h34, 1'b0, 1'b0, 4'd0, rrfp_pkg::KIND_INT, 64'd0, 1'b0},
    '{OP_BYTE, 1'b0, 32'h56, 1'b0, 1'b0, 4'd0, rrfp_pkg::KIND_INT, 64'd0, 1'b0},
    '{OP_BYTE, 1'b0, 32'h78, 1'b1, 1'b1, 4'd3, rrfp_pkg::KIND_INT, 64'h1234_5678, 1'b1},
    // record cut short in the first column
    '{OP_BYTE, 1'b0, 32'hFF, 1'b1, 1'b1, 4'd0, rrfp_pkg::KIND_FRAME_ERR, 64'd0, 1'b0}
  };

  // schema and parse state as the predictor sees them
  logic [4:0]       s_count;
  logic [31:0]      s_types;
  logic [4:0]       p_col;
  rrfp_pkg::phase_t p_phase;
  logic [16:0]      p_left;
  logic [63:0]      p_acc;
  logic             p_overrun;

  rrfp_pkg::result_t expected_fields [$];
  logic [7:0] rec_b [$];
  bit         rec_e [$];

  int  errors, results_seen, frames_seen, bytes_sent, rows_sent, schemas, cycles;
  bit  long_hold, rx_calm, tx_calm;

  function automatic logic [4:0] eff_cols(input logic [4:0] n);
    if (n == 5'd0) return 5'd1;
    if (n > MAX_COLUMNS) return 5'(MAX_COLUMNS);
    return n;
  endfunction

  function automatic void clear_parse();
    p_col     = '0;
    p_phase   = rrfp_pkg::PH_START;
    p_left    = '0;
    p_acc     = '0;
    p_overrun = 1'b0;
  endfunction

  function automatic void predict_field(input logic [7:0] b, input logic eor,
                                        output logic has, output rrfp_pkg::result_t r);
    logic [4:0]  ncols;
    logic [1:0]  t;
    logic        cdone;
    logic [15:0] len;
    ncols = eff_cols(s_count);
    has   = 1'b0;
    cdone = 1'b0;
    r     = '0;
    r.column_index = p_col[3:0];
    if (p_overrun || p_col >= ncols) begin
      p_overrun = 1'b1;
    end else begin
      // live type of the current column, even if changed mid-record
      t = s_types[2*p_col[3:0] +: 2];
      case (p_phase)
        rrfp_pkg::PH_START: begin
          p_acc = {56'd0, b};
          if (t == rrfp_pkg::TYPE_INT32 || t == rrfp_pkg::TYPE_INT64) begin
            p_left  = (t == rrfp_pkg::TYPE_INT32) ? 17'd3 : 17'd7;
            p_phase = rrfp_pkg::PH_NUMBER;
          end else begin
            p_phase = rrfp_pkg::PH_LENGTH;
          end
        end
        rrfp_pkg::PH_NUMBER: begin
          p_acc  = {p_acc[55:0], b};
          p_left = p_left - 17'd1;
          if (p_left == '0) begin
            has   = 1'b1;
            cdone = 1'b1;
            if (t == rrfp_pkg::TYPE_INT64) begin
              r.item_kind   = rrfp_pkg::KIND_LONG;
              r.field_value = p_acc;
            end else begin
              r.item_kind   = rrfp_pkg::KIND_INT;
              r.field_value = {{32{p_acc[31]}}, p_acc[31:0]};
            end
          end
        end
        rrfp_pkg::PH_LENGTH: begin
          len           = {p_acc[7:0], b};
          has           = 1'b1;
          r.item_kind   = (t == rrfp_pkg::TYPE_STRING) ?
                          rrfp_pkg::KIND_STR_LEN : rrfp_pkg::KIND_BLOB_LEN;
          r.field_value = {48'd0, len};
          p_acc         = {48'd0, len};
          if (len == '0) begin
            cdone = 1'b1;
          end else begin
            p_left  = {1'b0, len};
            p_phase = rrfp_pkg::PH_PAYLOAD;
          end
        end
        default: begin
          has           = 1'b1;
          r.item_kind   = (t == rrfp_pkg::TYPE_STRING) ?
                          rrfp_pkg::KIND_STR_BYTE : rrfp_pkg::KIND_BLOB_BYTE;
          r.field_value = {56'd0, b};
          p_left        = p_left - 17'd1;
          if (p_left == '0) cdone = 1'b1;
        end
      endcase
      if (cdone) begin
        p_col   = p_col + 5'd1;
        p_phase = rrfp_pkg::PH_START;
        p_left  = '0;
        p_acc   = '0;
      end
    end
    if (eor) begin
      if (!(has && cdone && !p_overrun && p_col == ncols)) begin
        r.column_index = (p_col > 5'd15) ? 4'd15 : p_col[3:0];
        r.item_kind    = rrfp_pkg::KIND_FRAME_ERR;
        r.field_value  = '0;
        cdone          = 1'b0;
      end
      has = 1'b1;
      clear_parse();
    end
    r.column_done = cdone;
    r.row_done    = eor;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // offer one byte, return at the edge where the transfer happens
  task automatic send_byte(input logic [7:0] b, input logic e, input logic typed,
                           input rrfp_pkg::result_t want);
    int                gap;
    logic              has;
    rrfp_pkg::result_t r;
    gap = tx_calm ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      data_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    data_valid    <= 1'b1;
    data_byte     <= b;
    end_of_record <= e;
    do @(posedge clk); while (data_stall);
    predict_field(b, e, has, r);
    if (typed) expected_fields.insert(expected_fields.size(), want);
    else if (has) expected_fields.insert(expected_fields.size(), r);
    bytes_sent++;
    if (e) rows_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    data_valid <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk);
    // a silent byte may still be in flight behind the last result
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    if (idx == rrfp_pkg::REG_COLUMN_COUNT) s_count = v[4:0];
    else s_types = v;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic reconfigure();
    logic [4:0]  cnt;
    logic [31:0] ty;
    int          r;
    drain();
    case (schemas)
      0: begin cnt = 5'd0;  ty = 32'h0000_0000; end
      1: begin cnt = 5'd31; ty = 32'hFFFF_FFFF; end
      2: begin cnt = 5'd16; ty = 32'hAAAA_AAAA; end
      3: begin cnt = 5'd1;  ty = 32'h5555_5555; end
      default: begin
        r = $urandom_range(0, 99);
        if (r < 55) cnt = 5'($urandom_range(1, 4));
        else if (r < 90) cnt = 5'($urandom_range(1, 16));
        else cnt = 5'($urandom_range(0, 31));
        r = $urandom_range(0, 9);
        ty = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
      end
    endcase
    // upper data bits of the count write are don't-care
    write_reg(rrfp_pkg::REG_COLUMN_COUNT, {27'($urandom_range(0, 32'h07FF_FFFF)), cnt});
    write_reg(rrfp_pkg::REG_COLUMN_TYPES, ty);
    schemas++;
    tx_calm = ($urandom_range(0, 4) == 0);
    rx_calm = ($urandom_range(0, 4) == 0);
  endtask

  // one row: mostly well-formed for the live schema, some broken, some noise
  task automatic build_record();
    int         pick, ncol, len, n, r;
    logic [1:0] t;
    rec_b.delete();
    rec_e.delete();
    pick = $urandom_range(0, 99);
    if (pick >= 88) begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        rec_b.insert(rec_b.size(), rand_byte());
        rec_e.insert(rec_e.size(), $urandom_range(0, 5) == 0);
      end
      rec_e[n-1] = 1'($urandom_range(0, 1));
      return;
    end
    ncol = eff_cols(s_count);
    for (int c = 0; c < ncol; c++) begin
      t = s_types[2*c +: 2];
      if (t == rrfp_pkg::TYPE_INT32 || t == rrfp_pkg::TYPE_INT64) begin
        repeat ((t == rrfp_pkg::TYPE_INT32) ? 4 : 8) begin
          rec_b.insert(rec_b.size(), rand_byte());
          rec_e.insert(rec_e.size(), 1'b0);
        end
      end else begin
        r = $urandom_range(0, 99);
        len = (r < 70) ? $urandom_range(0, 4) :
              (r < 95) ? $urandom_range(5, 40) : $urandom_range(41, 300);
        rec_b.insert(rec_b.size(), 8'(len >> 8));
        rec_b.insert(rec_b.size(), 8'(len));
        rec_e.insert(rec_e.size(), 1'b0);
        rec_e.insert(rec_e.size(), 1'b0);
        repeat (len) begin
          rec_b.insert(rec_b.size(), rand_byte());
          rec_e.insert(rec_e.size(), 1'b0);
        end
      end
    end
    rec_e[rec_e.size()-1] = 1'b1;
    if (pick >= 75) begin
      r = $urandom_range(0, 2);
      if (r == 0 && rec_b.size() > 1) begin
        n = $urandom_range(1, rec_b.size() - 1);
        repeat (n) begin
          void'(rec_b.pop_back());
          void'(rec_e.pop_back());
        end
        rec_e[rec_e.size()-1] = 1'b1;
      end else if (r == 1) begin
        rec_e[rec_e.size()-1] = 1'b0;
        repeat ($urandom_range(1, 4)) begin
          rec_b.insert(rec_b.size(), rand_byte());
          rec_e.insert(rec_e.size(), 1'b0);
        end
        rec_e[rec_e.size()-1] = 1'b1;
      end else begin
        // no end marker: the next row runs on past the last column
        rec_e[rec_e.size()-1] = 1'b0;
      end
    end
  endtask

  // result side: random stall, plus long hold-offs on request
  initial begin : result_side
    int n;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        n = HOLD_CYCLES;
        long_hold = 1'b0;
      end else begin
        n = rx_calm ? 0 : pick_gap();
      end
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    rrfp_pkg::result_t got, want;
    if (!rst && result_valid && !result_stall) begin
      got = {column_index, item_kind, field_value, column_done, row_done};
      results_seen++;
      if (got.item_kind == rrfp_pkg::KIND_FRAME_ERR) frames_seen++;
      if (expected_fields.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected transfer: col %0d kind %0d value %h done %b row %b",
                   got.column_index, got.item_kind, got.field_value,
                   got.column_done, got.row_done);
      end else begin
        want = expected_fields.pop_front();
        if (got.column_index !== want.column_index || got.item_kind !== want.item_kind ||
            got.field_value !== want.field_value || got.column_done !== want.column_done ||
            got.row_done !== want.row_done) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch at result %0d", results_seen);
            $display("  expected col %0d kind %0d value %h done %b row %b",
                     want.column_index, want.item_kind, want.field_value,
                     want.column_done, want.row_done);
            $display("  actual   col %0d kind %0d value %h done %b row %b",
                     got.column_index, got.item_kind, got.field_value,
                     got.column_done, got.row_done);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_fields.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int sent, mid;
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    data_valid    = 1'b0;
    data_byte     = '0;
    end_of_record = 1'b0;
    long_hold     = 1'b0;
    rx_calm       = 1'b0;
    tx_calm       = 1'b0;
    s_count       = 5'd1;
    s_types       = '0;
    clear_parse();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].op == OP_CFG) begin
        drain();
        write_reg(script[i].idx, script[i].data);
      end else begin
        send_byte(script[i].data[7:0], script[i].eor, script[i].typed,
                  {script[i].col, script[i].kind, script[i].val, script[i].cd,
                   script[i].eor});
      end
    end

    sent = 0;
    while (sent < N_RANDOM) begin
      if (sent == 0 || $urandom_range(0, 11) == 0) reconfigure();
      if (sent == 0 || (sent >= N_RANDOM / 2 && sent < N_RANDOM / 2 + 20 && !long_hold)) begin
        // output side holds off while bytes keep coming
        long_hold = 1'b1;
        tx_calm   = 1'b1;
      end
      build_record();
      mid = (rec_b.size() > 1 && $urandom_range(0, 24) == 0) ?
            $urandom_range(1, rec_b.size() - 1) : -1;
      foreach (rec_b[i]) begin
        if (i == mid) reconfigure();
        send_byte(rec_b[i], rec_e[i], 1'b0, '0);
        sent++;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    errors += expected_fields.size();
    $display("sent %0d bytes, %0d marked rows, over %0d schema settings",
             bytes_sent, rows_sent, schemas);
    $display("checked %0d results, %0d of them framing errors; %0d mismatches",
             results_seen, frames_seen, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
